>>> hw/rtl/tcw_pkg.sv
// Shared constants, codes and defaults of the text console cell writer.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int MAX_COLS_DEF  = 128;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int TAB_WIDTH_DEF = 8;

   localparam int RESET_COLS = 80;
   localparam int RESET_ROWS = 25;

   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int CELL_W     = 16;

   localparam logic [KIND_W-1:0] KIND_PUT     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TAB     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GOTO    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE = 2'd2;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, SPACE_CHAR};

endpackage

>>> hw/rtl/tcw_cell_store.sv
// Cell memory with one write port and one registered read port.
`timescale 1ns / 1ps

module tcw_cell_store #(
   parameter int DEPTH = tcw_pkg::MAX_COLS_DEF * tcw_pkg::MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] cell_mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= cell_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/text_console_cell_writer.sv
// Text console cell writer: cursor control and sequencing around the cell memory.
// Commands are sequenced around the single port pair of the cell memory: a tab
// writes its spaces one cell at a time, a scroll copies each row up through the
// read port and then blanks the last row, and a clear blanks every visible cell.
// Reset is synchronous; afterwards the whole store, MAX_COLS*MAX_ROWS cells (8192
// by default), is swept to spaces with attribute 0x07 while req_tready is low.
`timescale 1ns / 1ps

module text_console_cell_writer #(
   parameter int MAX_COLS  = tcw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS  = tcw_pkg::MAX_ROWS_DEF,
   parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code[7:0], target_col[15:8], target_row[22:16], cell_index[35:23],
   // cell_char[43:36], cell_attr[51:44], zeros above
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[2:0]
   input  logic [tcw_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_col[7:0], cursor_row[14:8], read_char[22:15], read_attr[30:23],
   // scrolled[31]
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcw_pkg::*;

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int PH_W   = $clog2(TAB_WIDTH + 1);
   localparam int PROD_W = ROW_W + COL_W;
   localparam int CMPC_W = (COL_W > 8) ? COL_W : 8;
   localparam int CMPR_W = (ROW_W > 7) ? ROW_W : 7;
   localparam int CMPI_W = (CNT_W > 13) ? CNT_W : 13;
   localparam int COLS_RST = (RESET_COLS > MAX_COLS) ? MAX_COLS : RESET_COLS;
   localparam int ROWS_RST = (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_PUT    = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;
   localparam logic [2:0] S_FILL   = 3'd5;
   localparam logic [2:0] S_READ   = 3'd6;
   localparam logic [2:0] S_HOLD   = 3'd7;

   // Column phase modulo the tab width, one entry per 1-based column.
   function automatic logic [MAX_COLS*PH_W-1:0] build_tab_phase();
      logic [MAX_COLS*PH_W-1:0] tbl;
      int ph;
      tbl = '0;
      ph = 1;
      for (int j = 0; j < MAX_COLS; j++) begin
         tbl[j*PH_W +: PH_W] = PH_W'(ph);
         ph = (ph == TAB_WIDTH - 1) ? 0 : ph + 1;
      end
      return tbl;
   endfunction

   localparam logic [MAX_COLS*PH_W-1:0] TAB_PHASE = build_tab_phase();

   logic [2:0]          state_ff, state_in;
   logic [COL_W-1:0]    cols_ff, cols_in;
   logic [ROW_W-1:0]    rows_ff, rows_in;
   logic [7:0]          attr_ff, attr_in;
   logic [CNT_W-1:0]    cells_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PH_W-1:0]     put_left_ff, put_left_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [7:0]          char_ff, char_in;
   logic [7:0]          tcol_ff, tcol_in;
   logic [6:0]          trow_ff, trow_in;
   logic [12:0]         cidx_ff, cidx_in;
   logic [CELL_W-1:0]   cdata_ff, cdata_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                scrolled_ff, scrolled_in;
   logic [CELL_W-1:0]   rd_cell_ff, rd_cell_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CELL_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CELL_W-1:0]   rd_data;

   logic                accept;
   logic                done;
   logic [COL_W-1:0]    eff_cols;
   logic [ROW_W-1:0]    eff_rows;
   logic [PROD_W-1:0]   put_idx;
   logic [CNT_W-1:0]    moved;
   logic [PH_W-1:0]     tab_phase;
   logic                cidx_ok;

   tcw_cell_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE) && !csr_we;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (csr_wdata == '0) begin
         eff_cols = COL_W'(1);
      end else if (CMPC_W'(csr_wdata) > CMPC_W'(MAX_COLS)) begin
         eff_cols = COL_W'(MAX_COLS);
      end else begin
         eff_cols = COL_W'(csr_wdata);
      end
      if (csr_wdata[6:0] == '0) begin
         eff_rows = ROW_W'(1);
      end else if (CMPR_W'(csr_wdata[6:0]) > CMPR_W'(MAX_ROWS)) begin
         eff_rows = ROW_W'(MAX_ROWS);
      end else begin
         eff_rows = ROW_W'(csr_wdata[6:0]);
      end
   end

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      attr_in = attr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS:   cols_in = eff_cols;
            CSR_ROWS:      rows_in = eff_rows;
            CSR_ATTRIBUTE: attr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign put_idx   = PROD_W'(row_ff - 1'b1) * PROD_W'(cols_ff) + PROD_W'(col_ff - 1'b1);
   assign moved     = cells_ff - CNT_W'(cols_ff);
   assign tab_phase = TAB_PHASE[(col_ff - 1'b1) * PH_W +: PH_W];
   assign cidx_ok   = CMPI_W'(cidx_ff) < CMPI_W'(DEPTH);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      put_left_in  = put_left_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      tcol_in      = tcol_ff;
      trow_in      = trow_ff;
      cidx_in      = cidx_ff;
      cdata_in     = cdata_ff;
      scrolled_in  = scrolled_ff;
      rd_cell_in   = rd_cell_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(put_idx);
      wr_data      = {attr_ff, char_ff};
      rd_addr      = ADDR_W'(cidx_ff);
      done         = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ADDR_W-1:0];
            wr_data = RESET_CELL;
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == CNT_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               kind_in     = req_tuser;
               char_in     = (req_tuser == KIND_TAB) ? SPACE_CHAR : req_tdata[7:0];
               tcol_in     = req_tdata[15:8];
               trow_in     = req_tdata[22:16];
               cidx_in     = req_tdata[35:23];
               cdata_in    = {req_tdata[51:44], req_tdata[43:36]};
               col_in      = (col_ff > cols_ff) ? cols_ff : col_ff;
               row_in      = (row_ff > rows_ff) ? rows_ff : row_ff;
               scrolled_in = 1'b0;
               rd_cell_in  = '0;
               put_left_in = '0;
               if (req_tuser == KIND_PUT) begin
                  put_left_in = PH_W'(1);
                  state_in    = S_PUT;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            unique case (kind_ff)
               KIND_NEWLINE: begin
                  col_in = COL_W'(1);
                  if (row_ff >= rows_ff) begin
                     scrolled_in = 1'b1;
                     ptr_in      = '0;
                     pend_in     = 1'b0;
                     state_in    = S_SCROLL;
                  end else begin
                     row_in = row_ff + 1'b1;
                     done   = 1'b1;
                  end
               end
               KIND_TAB: begin
                  put_left_in = PH_W'(TAB_WIDTH) - tab_phase;
                  state_in    = S_PUT;
               end
               KIND_GOTO: begin
                  if (tcol_ff == '0) begin
                     col_in = COL_W'(1);
                  end else if (CMPC_W'(tcol_ff) > CMPC_W'(cols_ff)) begin
                     col_in = cols_ff;
                  end else begin
                     col_in = COL_W'(tcol_ff);
                  end
                  if (trow_ff == '0) begin
                     row_in = ROW_W'(1);
                  end else if (CMPR_W'(trow_ff) > CMPR_W'(rows_ff)) begin
                     row_in = rows_ff;
                  end else begin
                     row_in = ROW_W'(trow_ff);
                  end
                  done = 1'b1;
               end
               KIND_CLEAR: begin
                  col_in   = COL_W'(1);
                  row_in   = ROW_W'(1);
                  ptr_in   = '0;
                  state_in = S_FILL;
               end
               KIND_WRITE: begin
                  wr_en   = cidx_ok;
                  wr_addr = ADDR_W'(cidx_ff);
                  wr_data = cdata_ff;
                  done    = 1'b1;
               end
               KIND_READ: begin
                  if (cidx_ok) begin
                     state_in = S_READ;
                  end else begin
                     done = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_PUT: begin
            wr_en       = 1'b1;
            put_left_in = put_left_ff - 1'b1;
            if (col_ff >= cols_ff) begin
               col_in = COL_W'(1);
               if (row_ff >= rows_ff) begin
                  scrolled_in = 1'b1;
                  ptr_in      = '0;
                  pend_in     = 1'b0;
                  state_in    = S_SCROLL;
               end else begin
                  row_in = row_ff + 1'b1;
                  done   = (put_left_ff == PH_W'(1));
               end
            end else begin
               col_in = col_ff + 1'b1;
               done   = (put_left_ff == PH_W'(1));
            end
         end
         S_SCROLL: begin
            wr_en   = pend_ff;
            wr_addr = pend_addr_ff;
            wr_data = rd_data;
            rd_addr = ADDR_W'(ptr_ff + CNT_W'(cols_ff));
            if (ptr_ff < moved) begin
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[ADDR_W-1:0];
               ptr_in       = ptr_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ADDR_W-1:0];
            wr_data = {attr_ff, SPACE_CHAR};
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == cells_ff - 1'b1) begin
               if (put_left_ff != '0) begin
                  state_in = S_PUT;
               end else begin
                  done = 1'b1;
               end
            end
         end
         S_READ: begin
            rd_cell_in = rd_data;
            done       = 1'b1;
         end
         S_HOLD: begin
            done = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {scrolled_in, rd_cell_in[15:8], rd_cell_in[7:0],
                            7'(row_in), 8'(col_in)};
            state_in     = S_IDLE;
         end else begin
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cols_ff      <= COL_W'(COLS_RST);
         rows_ff      <= ROW_W'(ROWS_RST);
         attr_ff      <= RESET_ATTR;
         col_ff       <= COL_W'(1);
         row_ff       <= ROW_W'(1);
         put_left_ff  <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         attr_ff      <= attr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         put_left_ff  <= put_left_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff     <= CNT_W'(PROD_W'(cols_ff) * PROD_W'(rows_ff));
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      tcol_ff      <= tcol_in;
      trow_ff      <= trow_in;
      cidx_ff      <= cidx_in;
      cdata_ff     <= cdata_in;
      pend_addr_ff <= pend_addr_in;
      scrolled_ff  <= scrolled_in;
      rd_cell_ff   <= rd_cell_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
